// ===== sv/mrtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

  // crc-16 constants (reflected form)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // captures at or beyond this position never happen
  localparam int MAX_FRAME_BYTES = 256;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // operation codes
  localparam logic OP_BUILD   = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic REG_DEVICE_ADDRESS   = 1'b0;
  localparam logic REG_CAPTURE_POSITION = 1'b1;

  // one input beat
  typedef struct packed {
    logic        operation;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_count;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        frame_valid;
    logic [7:0]  captured_value;
    logic [15:0] error_count;
  } result_t;

  // command passed from front to back
  typedef struct packed {
    logic        kind;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_count;
    logic        frame_valid;
    logic [7:0]  captured_value;
    logic [15:0] error_count;
  } cmd_t;

  // one byte step of the crc, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mrtu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrtu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire mrtu_pkg::in_item_t item,
  input  wire logic [7:0]        capture_position,
  output logic                   cmd_push,
  output mrtu_pkg::cmd_t         cmd
);
  import mrtu_pkg::*;

  localparam logic [8:0] MaxFrame = 9'(MAX_FRAME_BYTES);

  logic [15:0] crc;
  logic [7:0]  pos;
  logic [7:0]  captured;
  logic [15:0] err_count;

  logic        is_rx;
  logic [15:0] crc_next;
  logic [7:0]  captured_next;
  logic        frame_ok;
  logic [15:0] err_count_next;

  // per-byte receive math
  always_comb begin
    is_rx          = accept && (item.operation == OP_RECEIVE);
    crc_next       = crc_byte(crc, item.rx_byte);
    captured_next  = ((pos == capture_position) && ({1'b0, capture_position} < MaxFrame))
                     ? item.rx_byte : captured;
    frame_ok       = (crc_next == 16'h0000);
    err_count_next = frame_ok ? err_count : err_count + 16'd1;
  end

  // command toward the back end
  always_comb begin
    cmd_push = accept && ((item.operation == OP_BUILD) || item.rx_last);
    cmd      = '0;
    if (item.operation == OP_BUILD) begin
      cmd.kind             = KIND_TX;
      cmd.function_code    = item.function_code;
      cmd.register_address = item.register_address;
      cmd.register_count   = item.register_count;
    end else begin
      cmd.kind           = KIND_STATUS;
      cmd.frame_valid    = frame_ok;
      cmd.captured_value = captured_next;
      cmd.error_count    = err_count_next;
    end
  end

  // receive frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      pos       <= 8'd0;
      captured  <= 8'd0;
      err_count <= 16'd0;
    end else if (is_rx) begin
      if (item.rx_last) begin
        crc       <= CRC_INIT;
        pos       <= 8'd0;
        captured  <= 8'd0;
        err_count <= err_count_next;
      end else begin
        crc      <= crc_next;
        captured <= captured_next;
        if (pos != 8'hFF) begin
          pos <= pos + 8'd1;
        end
      end
    end
  end

  // a frame end always leaves a fresh frame state
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.kind == KIND_STATUS) |=> (crc == CRC_INIT && pos == 8'd0))
    else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

// ===== sv/mrtu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrtu_queue #(
  parameter int DEPTH = mrtu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire mrtu_pkg::cmd_t wr_data,
  input  wire logic           rd_en,
  output mrtu_pkg::cmd_t      rd_data,
  output logic                q_full,
  output logic                q_empty
);
  import mrtu_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_full  = (count == FullCnt);
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!q_full || rd_en))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !q_empty)
    else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== sv/mrtu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mrtu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     device_address,
  input  wire mrtu_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  input  wire logic           pop,
  output logic                empty,
  output mrtu_pkg::result_t   result
);
  import mrtu_pkg::*;

  logic        out_valid;
  result_t     out_reg;
  logic        busy;
  logic [2:0]  idx;
  logic [15:0] crc;
  cmd_t        cur;

  logic        advance;
  logic [7:0]  tx_sel;
  result_t     out_next;

  assign empty   = !out_valid;
  assign result  = out_reg;
  assign advance = !out_valid || pop;
  assign cmd_pop = advance && !busy && !cmd_empty;

  // byte of the frame being built
  always_comb begin
    case (idx)
      3'd1:    tx_sel = cur.function_code;
      3'd2:    tx_sel = cur.register_address[15:8];
      3'd3:    tx_sel = cur.register_address[7:0];
      3'd4:    tx_sel = cur.register_count[15:8];
      3'd5:    tx_sel = cur.register_count[7:0];
      3'd6:    tx_sel = crc[7:0];
      3'd7:    tx_sel = crc[15:8];
      default: tx_sel = device_address;
    endcase
  end

  // beat loaded into the output register
  always_comb begin
    out_next = '0;
    if (busy) begin
      // next byte of a build
      out_next.result_kind = KIND_TX;
      out_next.tx_byte     = tx_sel;
      out_next.tx_last     = (idx == 3'd7);
    end else if (cmd.kind == KIND_STATUS) begin
      out_next.result_kind    = KIND_STATUS;
      out_next.frame_valid    = cmd.frame_valid;
      out_next.captured_value = cmd.captured_value;
      out_next.error_count    = cmd.error_count;
    end else begin
      // first byte of a build goes out as the command is taken
      out_next.result_kind = KIND_TX;
      out_next.tx_byte     = device_address;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      idx       <= 3'd0;
      crc       <= CRC_INIT;
      out_reg   <= '0;
      cur       <= '0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        out_reg   <= out_next;
        if (idx < 3'd6) begin
          crc <= crc_byte(crc, tx_sel);
        end
        idx <= idx + 3'd1;
        if (idx == 3'd7) begin
          busy <= 1'b0;
        end
      end else if (!cmd_empty) begin
        out_valid <= 1'b1;
        out_reg   <= out_next;
        if (cmd.kind != KIND_STATUS) begin
          cur  <= cmd;
          crc  <= crc_byte(CRC_INIT, device_address);
          idx  <= 3'd1;
          busy <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_index: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx != 3'd0))
    else $error("build sequencer index out of step");

  a_last_is_tx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.tx_last) |-> (out_reg.result_kind == KIND_TX && !busy))
    else $error("tx_last on a non-final or status beat");

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_frame_crc_unit.sv =====
// build: 8 beats per build, the first via the command queue and the output register, then one
//   per cycle while popped; the single byte-serial tx sequencer takes no command mid-build
// receive: one byte per cycle via the front crc step unless full; status via queue and output reg
// a small command queue between front and back lets input continue while results wait
// reset (synchronous, high): config to defaults, crc to 0xFFFF, counters and queue cleared
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_frame_crc_unit #(
  parameter int QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire mrtu_pkg::in_item_t item,
  output logic                    empty,
  input  wire logic               pop,
  output mrtu_pkg::result_t       result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import mrtu_pkg::*;

  logic [7:0] device_address;
  logic [7:0] capture_position;

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_pop;
  logic q_full;
  logic q_empty;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= 8'd1;
      capture_position <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS:   device_address   <= cfg_data;
        REG_CAPTURE_POSITION: capture_position <= cfg_data;
        default:              device_address   <= device_address;
      endcase
    end
  end

  mrtu_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .item             (item),
    .capture_position (capture_position),
    .cmd_push         (cmd_push),
    .cmd              (cmd_in)
  );

  mrtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mrtu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .cmd            (cmd_out),
    .cmd_empty      (q_empty),
    .cmd_pop        (cmd_pop),
    .pop            (pop),
    .empty          (empty),
    .result         (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mrtu_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 20;
  localparam logic [7:0]  DEV_ADDR_RST  = 8'd1;
  localparam logic [7:0]  CAP_POS_RST   = 8'd8;

  // what the driver does with one planned entry
  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e       act;
    in_item_t   beat;
    logic       idx;
    logic [7:0] data;
  } plan_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_item_t   item = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  plan_t      plan_q[$];
  result_t    frame_beats_due[$];
  int         mismatches = 0;
  int         beats_in = 0;
  int         settle_cnt = 0;
  int         cycles = 0;
  int         planned_items = 0;
  logic       gaps_on;

  // mirror of the block's registers and receive state
  logic [7:0]  mdl_dev_addr;
  logic [7:0]  mdl_cap_pos;
  logic [15:0] rx_crc;
  logic [7:0]  rx_pos;
  logic [7:0]  rx_captured;
  logic [15:0] rx_errors;

  modbus_rtu_frame_crc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one window of beats runs with no gaps on either side
  assign gaps_on = !(beats_in >= 200 && beats_in < 320);

  // reflected crc-16, one byte, xor-mask form
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {16{r[0]}});
    return r;
  endfunction

  function automatic void rx_clear();
    rx_crc      = CRC_INIT;
    rx_pos      = 8'h00;
    rx_captured = 8'h00;
  endfunction

  // expected beats for one accepted input beat
  function automatic void frame_model_step(input in_item_t it);
    logic [7:0]  fb [8];
    logic [15:0] c;
    result_t     r;
    int          k;
    if (it.operation == OP_BUILD) begin
      fb[0] = mdl_dev_addr;
      fb[1] = it.function_code;
      fb[2] = it.register_address[15:8];
      fb[3] = it.register_address[7:0];
      fb[4] = it.register_count[15:8];
      fb[5] = it.register_count[7:0];
      c = CRC_INIT;
      for (k = 0; k < 6; k++) c = crc_next(c, fb[k]);
      fb[6] = c[7:0];
      fb[7] = c[15:8];
      for (k = 0; k < 8; k++) begin
        r = '0;
        r.result_kind = KIND_TX;
        r.tx_byte     = fb[k];
        r.tx_last     = (k == 7);
        frame_beats_due.push_back(r);
      end
    end else begin
      rx_crc = crc_next(rx_crc, it.rx_byte);
      // an 8-bit position can never reach the buffer size, so no bound check
      if (rx_pos == mdl_cap_pos) rx_captured = it.rx_byte;
      if (rx_pos != 8'hFF) rx_pos = rx_pos + 8'd1;
      if (it.rx_last) begin
        r = '0;
        r.result_kind    = KIND_STATUS;
        r.frame_valid    = (rx_crc == 16'h0000);
        if (!r.frame_valid) rx_errors = rx_errors + 16'd1;
        r.captured_value = rx_captured;
        r.error_count    = rx_errors;
        frame_beats_due.push_back(r);
        rx_clear();
      end
    end
  endfunction

  function automatic void model_config(input logic idx, input logic [7:0] data);
    if (idx == REG_DEVICE_ADDRESS) mdl_dev_addr = data;
    else mdl_cap_pos = data;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // driver: input beats and register writes
  always @(posedge clk) begin : driver
    logic  item_taken;
    logic  cfg_taken;
    logic  nx_push;
    logic  nx_cfg;
    plan_t nx;
    if (rst) begin
      push         <= 1'b0;
      cfg_valid    <= 1'b0;
      mdl_dev_addr = DEV_ADDR_RST;
      mdl_cap_pos  = CAP_POS_RST;
      rx_errors    = 16'h0000;
      rx_clear();
      settle_cnt   = 0;
    end else begin
      item_taken = push && !full;
      cfg_taken  = cfg_valid && cfg_ready;
      if (item_taken) begin
        frame_model_step(item);
        beats_in++;
      end
      if (cfg_taken) model_config(cfg_index, cfg_data);
      if (frame_beats_due.size() == 0 && !item_taken) begin
        if (settle_cnt < SETTLE_CYCLES) settle_cnt++;
      end else begin
        settle_cnt = 0;
      end
      nx_push = push && !item_taken;
      nx_cfg  = cfg_valid && !cfg_taken;
      if (!nx_push && !nx_cfg && plan_q.size() != 0) begin
        case (plan_q[0].act)
          ACT_ITEM: begin
            if (!(gaps_on && $urandom_range(99) < 7)) begin
              nx = plan_q.pop_front();
              nx_push = 1'b1;
              item <= nx.beat;
            end
          end
          ACT_CFG: begin
            // write only once the block has gone quiet
            if (settle_cnt >= SETTLE_CYCLES) begin
              nx = plan_q.pop_front();
              nx_cfg = 1'b1;
              cfg_index <= nx.idx;
              cfg_data  <= nx.data;
            end
          end
          default: begin
            if (frame_beats_due.size() == 0) nx = plan_q.pop_front();
          end
        endcase
      end
      push      <= nx_push;
      cfg_valid <= nx_cfg;
    end
  end

  // monitor: result beats against the oldest expectation
  always @(posedge clk) begin : monitor
    result_t exp_r;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_beats_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected: expected none actual %h",
                   $time, result);
        end else begin
          exp_r = frame_beats_due.pop_front();
          check_field("result_kind", exp_r.result_kind, result.result_kind);
          check_field("tx_byte", exp_r.tx_byte, result.tx_byte);
          check_field("tx_last", exp_r.tx_last, result.tx_last);
          check_field("frame_valid", exp_r.frame_valid, result.frame_valid);
          check_field("captured_value", exp_r.captured_value, result.captured_value);
          check_field("error_count", exp_r.error_count, result.error_count);
        end
      end
      pop <= !(gaps_on && $urandom_range(99) < 7);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t random_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic add_item(input in_item_t it);
    plan_t p;
    p.act  = ACT_ITEM;
    p.beat = it;
    p.idx  = 1'b0;
    p.data = 8'h00;
    plan_q.push_back(p);
    planned_items++;
  endtask

  task automatic add_build(input logic [7:0] fc, input logic [15:0] addr,
                           input logic [15:0] cnt);
    in_item_t it;
    it = random_beat();
    it.operation        = OP_BUILD;
    it.function_code    = fc;
    it.register_address = addr;
    it.register_count   = cnt;
    add_item(it);
  endtask

  task automatic add_random_build();
    logic [15:0] addr;
    logic [15:0] cnt;
    addr = $urandom;
    cnt  = $urandom;
    case ($urandom_range(7))
      0: addr = 16'h0000;
      1: addr = 16'hFFFF;
      2: cnt  = 16'h0000;
      3: cnt  = 16'hFFFF;
      default: ;
    endcase
    add_build($urandom, addr, cnt);
  endtask

  task automatic add_rx(input logic [7:0] b, input logic last);
    in_item_t it;
    it = random_beat();
    it.operation = OP_RECEIVE;
    it.rx_byte   = b;
    it.rx_last   = last;
    add_item(it);
  endtask

  task automatic add_cfg(input logic idx, input logic [7:0] data);
    plan_t p;
    p.act  = ACT_CFG;
    p.beat = '0;
    p.idx  = idx;
    p.data = data;
    plan_q.push_back(p);
  endtask

  task automatic add_drain();
    plan_t p;
    p.act  = ACT_DRAIN;
    p.beat = '0;
    p.idx  = 1'b0;
    p.data = 8'h00;
    plan_q.push_back(p);
  endtask

  // a received frame; a good one of two or more bytes carries its own crc, a bad one has a flipped byte
  task automatic add_frame(input int len, input logic good, input logic mid_build,
                           input int build_pct);
    logic [7:0]  fb[$];
    logic [15:0] c;
    int          k;
    c = CRC_INIT;
    for (k = 0; k < len - 2; k++) begin
      fb.push_back($urandom);
      c = crc_next(c, fb[k]);
    end
    if (len >= 2) begin
      fb.push_back(c[7:0]);
      fb.push_back(c[15:8]);
    end else begin
      fb.push_back($urandom);
    end
    if (!good) begin
      k = $urandom_range(fb.size() - 1);
      fb[k] = fb[k] ^ 8'($urandom_range(255, 1));
    end
    for (k = 0; k < fb.size(); k++) begin
      if ((mid_build && k == fb.size() / 2) || $urandom_range(99) < build_pct)
        add_random_build();
      add_rx(fb[k], k == fb.size() - 1);
    end
  endtask

  function automatic logic [7:0] pick_extreme();
    case ($urandom_range(2))
      0: return 8'h00;
      1: return 8'hFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_capture();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(12));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0] known_frame [8];
    int         k;
    int         target;
    int         phase_end;
    int         pick;
    known_frame = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h0A, 8'hC5, 8'hCD};

    // directed: field extremes, a known good frame, short and broken frames
    add_build(8'h00, 16'h0000, 16'h0000);
    add_build(8'hFF, 16'hFFFF, 16'hFFFF);
    add_build(8'h03, 16'h0000, 16'h000A);
    // frame ends before the capture position
    for (k = 0; k < 8; k++) add_rx(known_frame[k], k == 7);
    // one-byte frame
    add_rx(8'hFF, 1'b1);
    // build in the middle of a frame, then a bad frame
    add_frame(5, 1'b1, 1'b1, 0);
    add_frame(3, 1'b0, 1'b0, 0);
    // first byte captured, device address extremes
    add_cfg(REG_DEVICE_ADDRESS, 8'h00);
    add_cfg(REG_CAPTURE_POSITION, 8'h00);
    add_frame(4, 1'b1, 1'b0, 0);
    add_build(8'h10, 16'h1234, 16'h5678);
    add_drain();

    // long frame: position saturates, capture at the top keeps the last byte
    add_cfg(REG_DEVICE_ADDRESS, 8'hFF);
    add_cfg(REG_CAPTURE_POSITION, 8'hFF);
    add_frame(262, 1'b1, 1'b0, 2);

    // random phases, each with its own register setting
    target = planned_items + 40;
    while (planned_items < target) begin
      add_cfg(REG_DEVICE_ADDRESS, pick_extreme());
      add_cfg(REG_CAPTURE_POSITION, pick_capture());
      phase_end = planned_items + 20;
      while (planned_items < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 20) add_random_build();
        else if (pick < 25) add_frame($urandom_range(6, 1), 1'b0, 1'b0, 30);
        else add_frame($urandom_range(12, 1), $urandom_range(99) < 80, 1'b0, 10);
        if ($urandom_range(99) < 4) add_drain();
      end
    end

    // reset, then wait for the plan to play out
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (plan_q.size() != 0 || push || cfg_valid || frame_beats_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
